### rtl/core/wat_pkg.sv
// ============================================================================
// wat_pkg
// Shared types and constants for the weekly alarm table.
// ============================================================================
package wat_pkg;

    localparam int MODE_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int MASK_W   = 8;
    localparam int MIN_W    = 11;
    localparam int ACT_W    = 8;
    localparam int DOW_W    = 3;
    localparam int STATUS_W = 3;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_CHECK  = 3'd0,
        MODE_ADD    = 3'd1,
        MODE_MODIFY = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 3'd0,
        STAT_FULL  = 3'd1,
        STAT_BADIX = 3'd2,
        STAT_EMPTY = 3'd3,
        STAT_HIT   = 3'd4,
        STAT_NOHIT = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // one table entry as held in a cell
    typedef struct packed {
        logic              valid;
        logic [MASK_W-1:0] mask;
        logic [MIN_W-1:0]  minute;
        logic [ACT_W-1:0]  action;
    } entry_t;

    // latched request, broadcast to every cell
    typedef struct packed {
        mode_t             mode;
        logic [SLOT_W-1:0] slot;
        logic [MASK_W-1:0] mask;
        logic [MIN_W-1:0]  minute;
        logic [ACT_W-1:0]  action;
        logic [MIN_W-1:0]  now_min;
        logic [DOW_W-1:0]  dow;
    } key_t;

    // controller to cell commands
    typedef struct packed {
        logic start;      // token to first cell
        logic step;       // token moves one cell up
        logic wr_entry;   // token cell takes whole entry, becomes valid
        logic wr_action;  // token cell takes action only
        logic shift;      // cells at or above slot take neighbor entry
        logic clear_all;  // drop all valid bits
    } cmd_t;

    // report of the token cell, zero from all others
    typedef struct packed {
        logic             valid;
        logic             dup;
        logic             hit;
        logic [ACT_W-1:0] action;
    } rep_t;

endpackage

### rtl/core/wat_cell.sv
// ============================================================================
// wat_cell
// One alarm entry with its scan token and local compare logic.
// ============================================================================
module wat_cell
    import wat_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  cmd_t   cmd,
    input  key_t   key,
    input  logic   token_in,
    output logic   token_out,
    input  entry_t up,
    output entry_t entry,
    output rep_t   rep
);

    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(INDEX);

    logic              token_reg, token_next;
    logic              valid_reg, valid_next;
    logic [MASK_W-1:0] mask_reg;
    logic [MIN_W-1:0]  minute_reg;
    logic [ACT_W-1:0]  action_reg;
    logic              shift_here;
    logic              wr_here;
    logic              wr_act_here;

    assign shift_here  = cmd.shift && (MY_IDX >= key.slot);
    assign wr_here     = token_reg && cmd.wr_entry;
    assign wr_act_here = token_reg && cmd.wr_action;

    always_comb
    begin
        if (cmd.start)
        begin
            token_next = (INDEX == 0);
        end
        else if (cmd.step)
        begin
            token_next = token_in;
        end
        else
        begin
            token_next = token_reg;
        end

        if (cmd.clear_all)
        begin
            valid_next = 1'b0;
        end
        else if (shift_here)
        begin
            valid_next = up.valid;
        end
        else if (wr_here)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            token_reg <= token_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_here)
        begin
            mask_reg   <= up.mask;
            minute_reg <= up.minute;
            action_reg <= up.action;
        end
        else if (wr_here)
        begin
            mask_reg   <= key.mask;
            minute_reg <= key.minute;
            action_reg <= key.action;
        end
        else if (wr_act_here)
        begin
            action_reg <= key.action;
        end
    end

    assign token_out = token_reg;
    assign entry     = '{valid: valid_reg, mask: mask_reg, minute: minute_reg,
                         action: action_reg};

    // report only while holding the token
    always_comb
    begin
        rep.valid  = token_reg && valid_reg;
        rep.dup    = token_reg && (mask_reg == key.mask) && (minute_reg == key.minute);
        rep.hit    = token_reg && valid_reg && (minute_reg == key.now_min)
                     && mask_reg[key.dow];
        rep.action = token_reg ? action_reg : '0;
    end

endmodule

### rtl/core/wat_ctrl.sv
// ============================================================================
// wat_ctrl
// Request sequencer: walks the token along the cells and forms results.
// ============================================================================
module wat_ctrl
    import wat_pkg::*;
#(
    parameter int ENTRIES = 20
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [MODE_W-1:0]   s_tuser,
    input  rep_t                rep,
    output cmd_t                cmd,
    output key_t                key,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0] m_tuser,
    output logic                m_tlast
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PAD_W = M_DATA_W - SLOT_W - ACT_W;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    key_t              key_reg, key_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ACT_W-1:0]  pend_action_reg, pend_action_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [ACT_W-1:0]  out_action_reg, out_action_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              at_end;
    logic              slot_bad;
    logic [SLOT_W-1:0] cur_slot;

    assign out_free = !out_valid_reg || m_tready;
    assign at_end   = (idx_reg == IDX_W'(ENTRIES - 1));
    assign slot_bad = ({1'b0, key_reg.slot} >= (SLOT_W + 1)'(ENTRIES));
    assign cur_slot = SLOT_W'(idx_reg);

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        key_next         = key_reg;
        pend_valid_next  = pend_valid_reg;
        pend_action_next = pend_action_reg;
        pend_slot_next   = pend_slot_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_action_next  = out_action_reg;
        out_slot_next    = out_slot_reg;
        out_last_next    = out_last_reg;
        cmd              = '0;
        s_tready         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    key_next.mode    = mode_t'(s_tuser);
                    key_next.slot    = s_tdata[5:0];
                    key_next.mask    = s_tdata[13:6];
                    key_next.minute  = s_tdata[24:14];
                    key_next.action  = s_tdata[32:25];
                    key_next.now_min = s_tdata[43:33];
                    key_next.dow     = s_tdata[46:44];
                    cmd.start        = 1'b1;
                    idx_next         = '0;
                    pend_valid_next  = 1'b0;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                unique case (key_reg.mode)
                    MODE_CHECK:
                    begin
                        // a second hit can go out only once the first one fits
                        if (!(rep.hit && pend_valid_reg && !out_free))
                        begin
                            if (rep.hit)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = STAT_HIT;
                                    out_action_next = pend_action_reg;
                                    out_slot_next   = pend_slot_reg;
                                    out_last_next   = 1'b0;
                                end
                                pend_valid_next  = 1'b1;
                                pend_action_next = rep.action;
                                pend_slot_next   = cur_slot;
                            end
                            if (at_end)
                            begin
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                cmd.step = 1'b1;
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    end

                    MODE_ADD:
                    begin
                        if (out_free)
                        begin
                            if (rep.valid && rep.dup)
                            begin
                                cmd.wr_action   = 1'b1;
                                out_valid_next  = 1'b1;
                                out_status_next = STAT_DONE;
                                out_action_next = '0;
                                out_slot_next   = cur_slot;
                                out_last_next   = 1'b1;
                                state_next      = ST_IDLE;
                            end
                            else if (!rep.valid)
                            begin
                                // valid entries form a prefix: first gap is free slot
                                cmd.wr_entry    = 1'b1;
                                out_valid_next  = 1'b1;
                                out_status_next = STAT_DONE;
                                out_action_next = '0;
                                out_slot_next   = cur_slot;
                                out_last_next   = 1'b1;
                                state_next      = ST_IDLE;
                            end
                            else if (at_end)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STAT_FULL;
                                out_action_next = '0;
                                out_slot_next   = '0;
                                out_last_next   = 1'b1;
                                state_next      = ST_IDLE;
                            end
                            else
                            begin
                                cmd.step = 1'b1;
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    end

                    MODE_MODIFY, MODE_DELETE:
                    begin
                        if (out_free)
                        begin
                            if (slot_bad)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STAT_BADIX;
                                out_action_next = '0;
                                out_slot_next   = key_reg.slot;
                                out_last_next   = 1'b1;
                                state_next      = ST_IDLE;
                            end
                            else if (cur_slot == key_reg.slot)
                            begin
                                out_valid_next  = 1'b1;
                                out_action_next = '0;
                                out_slot_next   = key_reg.slot;
                                out_last_next   = 1'b1;
                                state_next      = ST_IDLE;
                                if (!rep.valid)
                                begin
                                    out_status_next = STAT_EMPTY;
                                end
                                else
                                begin
                                    out_status_next = STAT_DONE;
                                    if (key_reg.mode == MODE_MODIFY)
                                    begin
                                        cmd.wr_entry = 1'b1;
                                    end
                                    else
                                    begin
                                        cmd.shift = 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                cmd.step = 1'b1;
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    end

                    MODE_CLEAR:
                    begin
                        if (out_free)
                        begin
                            cmd.clear_all   = 1'b1;
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_DONE;
                            out_action_next = '0;
                            out_slot_next   = '0;
                            out_last_next   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end

                    default:
                    begin
                        // unused modes just acknowledge
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_DONE;
                            out_action_next = '0;
                            out_slot_next   = '0;
                            out_last_next   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_valid_reg ? STAT_HIT : STAT_NOHIT;
                    out_action_next = pend_valid_reg ? pend_action_reg : '0;
                    out_slot_next   = pend_valid_reg ? pend_slot_reg : '0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        pend_action_reg <= pend_action_next;
        pend_slot_reg   <= pend_slot_next;
        out_status_reg  <= out_status_next;
        out_action_reg  <= out_action_next;
        out_slot_reg    <= out_slot_next;
        out_last_reg    <= out_last_next;
    end

    assign key      = key_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_slot_reg, out_action_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

### rtl/core/weekly_alarm_table_top.sv
// ============================================================================
// weekly_alarm_table_top
// Packed table of weekly alarms held in a chain of entry cells.
// ============================================================================
// Operation: a token walks the cells one per cycle unless an output stall holds
//   it. Add, modify and delete stop at the cell concerned, with the result
//   registered. A check walks all ENTRIES cells, then a flush state forms its
//   final result.
// Requests: one at a time, set by the single token walking the chain.
//   Output stalls hold the walk.
// Reset: all valid bits, the token and the output valid flag clear at once.
// ============================================================================
module weekly_alarm_table_top
    import wat_pkg::*;
#(
    parameter int ENTRIES = 20   // 1 .. 64
)
(
    input  logic                clk,
    input  logic                rst_n,

    // request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // slot[5:0], day_mask[13:6], alarm_minute[24:14], action_code[32:25],
    // now_minute[43:33], day_of_week[46:44], zero pad[47]
    input  logic [S_DATA_W-1:0] s_tdata,
    // mode[2:0]
    input  logic [MODE_W-1:0]   s_tuser,

    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // hit_action[7:0], hit_slot[13:8], zero pad[15:14]
    output logic [M_DATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [STATUS_W-1:0] m_tuser,
    // last result of a request
    output logic                m_tlast
);

    cmd_t               cmd;
    key_t               key;
    rep_t               rep_all;
    rep_t               rep_arr   [ENTRIES];
    entry_t             ent_arr   [ENTRIES];
    logic [ENTRIES-1:0] tok_vec;
    logic [ENTRIES-1:0] valid_vec;

    // Cell i looks at cell i+1 for the delete shift; the top cell pulls in an
    // empty entry. The token enters at cell 0 and moves upward.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        entry_t up_ent;
        logic   tok_in;

        if (i == ENTRIES - 1)
        begin : g_top
            assign up_ent = '0;
        end
        else
        begin : g_mid
            assign up_ent = ent_arr[i + 1];
        end

        if (i == 0)
        begin : g_first
            assign tok_in = 1'b0;
        end
        else
        begin : g_next
            assign tok_in = tok_vec[i - 1];
        end

        wat_cell #(
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .key       (key),
            .token_in  (tok_in),
            .token_out (tok_vec[i]),
            .up        (up_ent),
            .entry     (ent_arr[i]),
            .rep       (rep_arr[i])
        );

        assign valid_vec[i] = ent_arr[i].valid;
    end

    // only the token cell reports, so an OR picks its report
    always_comb
    begin
        rep_all = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rep_all = rep_all | rep_arr[i];
        end
    end

    wat_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .rep      (rep_all),
        .cmd      (cmd),
        .key      (key),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // never more than one token in the chain
    a_token_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one cell holds the scan token");

    // valid entries always form a prefix of the table
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("alarm table is no longer packed");

    // an entry write lands in exactly one cell
    a_write_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_entry || cmd.wr_action) |-> $onehot(tok_vec))
        else $error("entry write without a single token holder");

    // a new request is only taken with the chain at rest
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !(cmd.step || cmd.shift || cmd.wr_entry || cmd.clear_all))
        else $error("request accepted while the chain is busy");

endmodule
